>>> rtl/hbc_pkg.sv
// Shared constants and types for the histogram bar chart block.
`default_nettype none

package hbc_pkg;

  localparam int NUM_BINS         = 256;
  localparam int BIN_W            = $clog2(NUM_BINS);
  localparam int COUNT_LIMIT_LOG2 = 20;
  localparam int CNT_W            = 21;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << COUNT_LIMIT_LOG2;
  localparam int CHART_ROWS       = 256;
  localparam int ROW_W            = 8;
  localparam int HEIGHT_W         = 9;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(200);
  localparam int STEP_W           = $clog2(CNT_W);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ACCUM  = 2'd1,
    OP_FINISH = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  localparam logic KIND_FINISH = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/hbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/hbc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module hbc_div import hbc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign shifted = {rem_r, quo_r[CNT_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(CNT_W - 1);
        quo_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_r <= {quo_r[CNT_W-2:0], fits};
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

>>> rtl/histogram_bar_chart.sv
// Query: bin read, the 21-bit divider, then result load. Finish: a 256-entry
// peak scan at one bin store read per cycle, then the 21-bit divider.
// The divider is shared by finish and query; the bin store has one read port.
// A synchronous active-low reset clears all bin valid bits, so every bin reads
// zero, peak to zero, divisor to one and target height to 200.
`default_nettype none

module histogram_bar_chart import hbc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [HEIGHT_W-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_operation,
  input  wire logic [7:0]          in_pixel_value,
  input  wire logic [7:0]          in_bin_index,
  input  wire logic [7:0]          in_chart_row,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_result_kind,
  output logic [CNT_W-1:0]         out_scaled_height,
  output logic                     out_dark_pixel,
  output logic [CNT_W-1:0]         out_peak_count,
  output logic [CNT_W-1:0]         out_scale_divisor
);

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_SCAN, S_FIN_TAIL, S_FIN_DIV, S_QRY_RD, S_QRY_DIV, S_PUT
  } state_t;

  state_t              state_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [NUM_BINS-1:0] vld_r;
  logic                vld_q_r;
  logic [BIN_W-1:0]    addr_r;
  logic [BIN_W-1:0]    idx_r;
  logic                pend_r;
  logic [CNT_W-1:0]    pk_r;
  logic [CNT_W-1:0]    peak_r;
  logic [CNT_W-1:0]    div_r;
  logic [ROW_W-1:0]    row_r;
  logic                res_kind_r;
  logic [CNT_W-1:0]    res_scaled_r;
  logic                res_dark_r;
  logic                out_valid_r;
  logic                out_kind_r;
  logic [CNT_W-1:0]    out_scaled_r;
  logic                out_dark_r;
  logic [CNT_W-1:0]    out_peak_r;
  logic [CNT_W-1:0]    out_div_r;

  logic                accept;
  op_t                 op;
  logic [BIN_W-1:0]    rd_addr;
  logic [CNT_W-1:0]    rd_data;
  logic [CNT_W-1:0]    count;
  logic                ram_we;
  logic [CNT_W-1:0]    pk_max;
  logic [CNT_W-1:0]    height_eff;
  logic [CNT_W:0]      row_sum;
  logic                out_free;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(in_operation);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (op == OP_ACCUM) ? in_pixel_value : in_bin_index;
    end else begin
      rd_addr = idx_r;
    end
  end

  // Bins never written since the last clear read as zero.
  assign count  = vld_q_r ? rd_data : '0;
  assign ram_we = (state_r == S_ACC) && (count < COUNT_LIMIT);
  assign pk_max = (count > pk_r) ? count : pk_r;

  assign height_eff = (height_r == '0) ? CNT_W'(1) : CNT_W'(height_r);
  assign row_sum    = {1'b0, div_rsp.quotient} + (CNT_W+1)'(row_r);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = count;
    div_req.divisor  = div_r;
    if (state_r == S_FIN_TAIL) begin
      div_req.start    = 1'b1;
      div_req.dividend = pk_max;
      div_req.divisor  = height_eff;
    end else if (state_r == S_QRY_RD) begin
      div_req.start = 1'b1;
    end
  end

  hbc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (count + 1'b1),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      height_r    <= HEIGHT_RESET;
      vld_r       <= '0;
      vld_q_r     <= 1'b0;
      pend_r      <= 1'b0;
      peak_r      <= '0;
      div_r       <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      vld_q_r <= vld_r[rd_addr];
      if (cfg_wr_en) begin
        height_r <= cfg_wr_data;
      end
      // Drop the word once taken; a load in S_PUT refills it instead.
      if (out_valid_r && !out_stall && state_r != S_PUT) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        vld_r[addr_r] <= 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            addr_r <= rd_addr;
            row_r  <= in_chart_row;
            idx_r  <= '0;
            pk_r   <= '0;
            pend_r <= 1'b0;
            case (op)
              OP_CLEAR:  vld_r   <= '0;
              OP_ACCUM:  state_r <= S_ACC;
              OP_FINISH: state_r <= S_SCAN;
              OP_QUERY:  state_r <= S_QRY_RD;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_ACC: begin
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          // Compare the word read last cycle while issuing the next address.
          pend_r <= 1'b1;
          if (pend_r) begin
            pk_r <= pk_max;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == BIN_W'(NUM_BINS - 1)) begin
            state_r <= S_FIN_TAIL;
          end
        end
        S_FIN_TAIL: begin
          peak_r  <= pk_max;
          state_r <= S_FIN_DIV;
        end
        S_FIN_DIV: begin
          if (div_rsp.done) begin
            div_r        <= (div_rsp.quotient == '0) ? CNT_W'(1) : div_rsp.quotient;
            res_kind_r   <= KIND_FINISH;
            res_scaled_r <= '0;
            res_dark_r   <= 1'b0;
            state_r      <= S_PUT;
          end
        end
        S_QRY_RD: begin
          state_r <= S_QRY_DIV;
        end
        S_QRY_DIV: begin
          if (div_rsp.done) begin
            res_kind_r   <= KIND_QUERY;
            res_scaled_r <= div_rsp.quotient;
            res_dark_r   <= row_sum >= (CNT_W+1)'(CHART_ROWS);
            state_r      <= S_PUT;
          end
        end
        S_PUT: begin
          // Hold until the output register is empty or being drained.
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= res_kind_r;
            out_scaled_r <= res_scaled_r;
            out_dark_r   <= res_dark_r;
            out_peak_r   <= peak_r;
            out_div_r    <= div_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_scaled_height = out_scaled_r;
  assign out_dark_pixel    = out_dark_r;
  assign out_peak_count    = out_peak_r;
  assign out_scale_divisor = out_div_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_r != '0)
    else $error("scale divisor reached zero");

  a_peak_limit: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= COUNT_LIMIT)
    else $error("peak above count limit");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_FIN_DIV || state_r == S_QRY_DIV))
    else $error("divider finished outside a divide state");

  a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result word not loaded");

endmodule

`default_nettype wire
